/* rtl/imh_pkg.sv */
// imh_pkg: codes and types shared by the indexed min-heap modules
// no dependencies
package imh_pkg;

  localparam int KEY_W = 8;
  localparam int VAL_W = 32;
  localparam int NKEYS = 256;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_DECR    = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

endpackage

/* rtl/indexed_min_heap.sv */
// indexed_min_heap: indexed binary min-heap with insert, extract-min, decrease-key
// each sift level takes a read state and a compare state (S_UPRD and S_UPCMP going up,
// S_DNRD and S_DNCMP going down); one request at a time, the next one taken the cycle
// after the result is accepted
// rst_n synchronous: count and key present bits clear at once, no clearing pass
// depends on imh_pkg, imh_heap_mem, imh_map_mem
module indexed_min_heap #(
  parameter int CAPACITY = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [imh_pkg::KEY_W-1:0]        in_item_key,
  input  logic signed [imh_pkg::VAL_W-1:0] in_item_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_status,
  output logic [imh_pkg::KEY_W-1:0]        out_min_key,
  output logic signed [imh_pkg::VAL_W-1:0] out_min_value,
  output logic                             out_now_empty
);

  localparam int SLOTS = (CAPACITY < imh_pkg::NKEYS) ? CAPACITY : imh_pkg::NKEYS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = AW + 1;
  localparam int KW    = imh_pkg::KEY_W;
  localparam int VW    = imh_pkg::VAL_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOOK  = 10'b0000000010,
    S_DEC   = 10'b0000000100,
    S_EXT   = 10'b0000001000,
    S_UPRD  = 10'b0000010000,
    S_UPCMP = 10'b0000100000,
    S_DNRD  = 10'b0001000000,
    S_DNCMP = 10'b0010000000,
    S_MAPW  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]    act_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [KW-1:0] ckey_r, ckey_nxt;
  logic [VW-1:0] cval_r, cval_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [KW-1:0] mk_r, mk_nxt;
  logic [VW-1:0] mv_r, mv_nxt;
  logic          ov_r;

  logic          hwe, mwe, mpres, rpres;
  logic [AW-1:0] hwa, ra_a, ra_b, mslot, rslot;
  logic [KW-1:0] hwk, mwa, rk_a, rk_b;
  logic [VW-1:0] hwv, rv_a, rv_b;

  imh_heap_mem #(.DEPTH(SLOTS), .AW(AW)) u_heap (
    .clk(clk), .we(hwe), .waddr(hwa), .wkey(hwk), .wval(hwv),
    .raddr_a(ra_a), .raddr_b(ra_b),
    .rkey_a(rk_a), .rval_a(rv_a), .rkey_b(rk_b), .rval_b(rv_b)
  );

  imh_map_mem #(.AW(AW)) u_map (
    .clk(clk), .rst_n(rst_n), .we(mwe), .waddr(mwa), .wpresent(mpres), .wslot(mslot),
    .raddr(in_item_key), .rpresent(rpres), .rslot(rslot)
  );

  assign in_stall = (state_r != S_IDLE) || ov_r;

  logic [AW:0]   lc, rc;
  logic          lok, rok, lsm, rsm;
  logic [AW-1:0] par, last;

  always_comb begin
    lc   = {pos_r, 1'b1};
    rc   = {pos_r, 1'b0} + {{AW{1'b0}}, 1'b1} + {{AW{1'b0}}, 1'b1};
    par  = (pos_r - AW'(1)) >> 1;
    last = AW'(cnt_r - CW'(1));
    lok  = lc < cnt_r;
    rok  = rc < cnt_r;
    lsm  = lok && ($signed(rv_a) < $signed(cval_r));
    rsm  = rok && ($signed(rv_b) < (lsm ? $signed(rv_a) : $signed(cval_r)));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; pos_nxt = pos_r; ckey_nxt = ckey_r; cval_nxt = cval_r;
    st_nxt = st_r; mk_nxt = mk_r; mv_nxt = mv_r;
    hwe = 1'b0; hwa = pos_r; hwk = ckey_r; hwv = cval_r;
    mwe = 1'b0; mwa = ckey_r; mpres = 1'b1; mslot = pos_r;
    ra_a = pos_r; ra_b = pos_r;
    case (state_r)
      S_IDLE: begin
        ra_a = '0; ra_b = last;
        if (in_valid && !in_stall) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        st_nxt = imh_pkg::ST_OK; mk_nxt = '0; mv_nxt = '0;
        ckey_nxt = key_r; cval_nxt = val_r;
        state_nxt = S_DONE;
        case (act_r)
          imh_pkg::ACT_INSERT: begin
            if (cnt_r >= CW'(SLOTS)) begin
              st_nxt = imh_pkg::ST_FULL;
            end else if (rpres) begin
              st_nxt = imh_pkg::ST_PRESENT;
            end else begin
              pos_nxt = AW'(cnt_r);
              cnt_nxt = cnt_r + CW'(1);
              state_nxt = S_UPRD;
            end
          end
          imh_pkg::ACT_EXTRACT: begin
            if (cnt_r == '0) begin
              st_nxt = imh_pkg::ST_EMPTY;
            end else begin
              mk_nxt = rk_a; mv_nxt = rv_a;
              ckey_nxt = rk_b; cval_nxt = rv_b;
              cnt_nxt = cnt_r - CW'(1);
              pos_nxt = '0;
              mwe = 1'b1; mwa = rk_a; mpres = 1'b0;
              state_nxt = (last == '0) ? S_DONE : S_DNRD;
            end
          end
          imh_pkg::ACT_DECR: begin
            if (!rpres) begin
              st_nxt = imh_pkg::ST_ABSENT;
            end else begin
              pos_nxt = rslot;
              state_nxt = S_DEC;
            end
          end
          default: ;
        endcase
      end
      S_DEC: begin
        state_nxt = S_EXT;
      end
      S_EXT: begin
        if ($signed(cval_r) < $signed(rv_a)) begin
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UPRD: begin
        ra_a = par;
        state_nxt = (pos_r == '0) ? S_MAPW : S_UPCMP;
      end
      S_UPCMP: begin
        if ($signed(cval_r) < $signed(rv_a)) begin
          hwe = 1'b1; hwa = pos_r; hwk = rk_a; hwv = rv_a;
          mwe = 1'b1; mwa = rk_a; mslot = pos_r;
          pos_nxt = par;
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_MAPW;
        end
      end
      S_DNRD: begin
        ra_a = lc[AW-1:0]; ra_b = rc[AW-1:0];
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (rsm) begin
          hwe = 1'b1; hwa = pos_r; hwk = rk_b; hwv = rv_b;
          mwe = 1'b1; mwa = rk_b; mslot = pos_r;
          pos_nxt = rc[AW-1:0];
          state_nxt = S_DNRD;
        end else if (lsm) begin
          hwe = 1'b1; hwa = pos_r; hwk = rk_a; hwv = rv_a;
          mwe = 1'b1; mwa = rk_a; mslot = pos_r;
          pos_nxt = lc[AW-1:0];
          state_nxt = S_DNRD;
        end else begin
          state_nxt = S_MAPW;
        end
      end
      S_MAPW: begin
        hwe = 1'b1; mwe = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // decrease read of the key's slot happens in S_DEC
    if (state_r == S_DEC) begin
      ra_a = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_DONE) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act_r <= in_action;
      key_r <= in_item_key;
      val_r <= in_item_value;
    end
    pos_r  <= pos_nxt;
    ckey_r <= ckey_nxt;
    cval_r <= cval_nxt;
    st_r   <= st_nxt;
    mk_r   <= mk_nxt;
    mv_r   <= mv_nxt;
  end

  assign out_valid     = ov_r;
  assign out_status    = st_r;
  assign out_min_key   = mk_r;
  assign out_min_value = mv_r;
  assign out_now_empty = (cnt_r == '0);

endmodule

/* rtl/imh_heap_mem.sv */
// imh_heap_mem: slot store, one (key, value) pair per heap slot
// depends on imh_pkg; one write port, two registered read ports
module imh_heap_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [imh_pkg::KEY_W-1:0]  wkey,
  input  logic [imh_pkg::VAL_W-1:0]  wval,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [imh_pkg::KEY_W-1:0]  rkey_a,
  output logic [imh_pkg::VAL_W-1:0]  rval_a,
  output logic [imh_pkg::KEY_W-1:0]  rkey_b,
  output logic [imh_pkg::VAL_W-1:0]  rval_b
);

  logic [imh_pkg::KEY_W+imh_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wkey, wval};
    end
    {rkey_a, rval_a} <= mem[raddr_a];
    {rkey_b, rval_b} <= mem[raddr_b];
  end

endmodule

/* rtl/imh_map_mem.sv */
// imh_map_mem: key to slot map with per-key present bits
// depends on imh_pkg; one write port, one registered read port
module imh_map_mem #(
  parameter int AW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      we,
  input  logic [imh_pkg::KEY_W-1:0] waddr,
  input  logic                      wpresent,
  input  logic [AW-1:0]             wslot,
  input  logic [imh_pkg::KEY_W-1:0] raddr,
  output logic                      rpresent,
  output logic [AW-1:0]             rslot
);

  logic [AW-1:0]             mem [imh_pkg::NKEYS];
  logic [imh_pkg::NKEYS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= wpresent;
    end
    if (we) begin
      mem[waddr] <= wslot;
    end
    rslot    <= mem[raddr];
    rpresent <= rst_n && vld_r[raddr] && !(we && waddr == raddr && !wpresent);
  end

endmodule

/* rtl/imh_checker.sv */
// imh_checker: port-level checks for indexed_min_heap
// depends on imh_pkg; bound to the top level below
module imh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [7:0] out_min_key,
  input logic       out_now_empty
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= imh_pkg::ST_PRESENT)
    else $error("bad status code");

  a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == imh_pkg::ST_EMPTY |-> out_min_key == '0 && out_now_empty)
    else $error("empty extract reported data");

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_status(out_status), .out_min_key(out_min_key), .out_now_empty(out_now_empty)
);

/* bench/indexed_min_heap_tb.sv */
// indexed_min_heap_tb: checks the indexed min-heap against a behavioral heap predictor
// with directed and random insert / extract / decrease-key / nop requests; depends on imh_pkg
`timescale 1ns / 100ps
module indexed_min_heap_tb;

  typedef struct packed {
    imh_pkg::action_t act;
    logic [7:0] key;
    logic signed [31:0] value;
  } heap_req_t;

  typedef struct packed {
    imh_pkg::status_t status;
    logic [7:0] min_key;
    logic signed [31:0] min_value;
    logic now_empty;
  } heap_resp_t;

  localparam int ABSENT_SLOT = 511;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [7:0] in_item_key = '0;
  logic signed [31:0] in_item_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_min_key;
  logic signed [31:0] out_min_value;
  logic out_now_empty;

  indexed_min_heap dut (.*);

  heap_req_t pending_reqs[$];
  heap_resp_t expected_resps[$];

  logic [7:0] hk[256];
  logic signed [31:0] hv[256];
  int key_slot[256];
  int count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int checked = 0;
  int cycles = 0;
  int n_extract = 0;
  bit in_taken = 1'b0;

  initial forever #2 clk = ~clk;

  function automatic void swap_slot(int a, int b);
    logic [7:0] k;
    logic signed [31:0] v;
    k = hk[a]; v = hv[a];
    hk[a] = hk[b]; hv[a] = hv[b];
    hk[b] = k; hv[b] = v;
    key_slot[hk[a]] = a;
    key_slot[hk[b]] = b;
  endfunction

  function automatic void bubble_up(int i);
    int p;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!(hv[i] < hv[p])) break;
      swap_slot(i, p);
      i = p;
    end
  endfunction

  function automatic void bubble_down(int i);
    int best, l, r;
    forever begin
      best = i;
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l < count && hv[l] < hv[best]) best = l;
      if (r < count && hv[r] < hv[best]) best = r;
      if (best == i) break;
      swap_slot(i, best);
      i = best;
    end
  endfunction

  function automatic heap_resp_t apply_heap_op(heap_req_t r);
    heap_resp_t o;
    int s;
    o = '{status: imh_pkg::ST_OK, min_key: '0, min_value: '0, now_empty: 1'b0};
    case (r.act)
      imh_pkg::ACT_INSERT: begin
        if (count >= 256) o.status = imh_pkg::ST_FULL;
        else if (key_slot[r.key] != ABSENT_SLOT) o.status = imh_pkg::ST_PRESENT;
        else begin
          hk[count] = r.key; hv[count] = r.value;
          key_slot[r.key] = count;
          count++;
          bubble_up(count - 1);
        end
      end
      imh_pkg::ACT_EXTRACT: begin
        if (count == 0) o.status = imh_pkg::ST_EMPTY;
        else begin
          o.min_key = hk[0]; o.min_value = hv[0];
          key_slot[hk[0]] = ABSENT_SLOT;
          count--;
          if (count != 0) begin
            hk[0] = hk[count]; hv[0] = hv[count];
            key_slot[hk[0]] = 0;
            bubble_down(0);
          end
        end
      end
      imh_pkg::ACT_DECR: begin
        s = key_slot[r.key];
        if (s == ABSENT_SLOT) o.status = imh_pkg::ST_ABSENT;
        else if (r.value < hv[s]) begin
          hv[s] = r.value;
          bubble_up(s);
        end
      end
      default: ;
    endcase
    o.now_empty = (count == 0);
    return o;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 7)) - 3;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic push(imh_pkg::action_t a, logic [7:0] k, logic signed [31:0] v);
    pending_reqs.push_back('{act: a, key: k, value: v});
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        heap_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_action <= r.act;
        in_item_key <= r.key;
        in_item_value <= r.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      heap_req_t r;
      r = '{act: imh_pkg::action_t'(in_action), key: in_item_key, value: in_item_value};
      expected_resps.push_back(apply_heap_op(r));
    end
    if (rst_n && out_valid && !out_stall) begin
      heap_resp_t e;
      checked++;
      if (expected_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", out_status);
      end else begin
        e = expected_resps.pop_front();
        if (e.min_key != 0 || e.min_value != 0) n_extract++;
        if (out_status !== e.status || out_min_key !== e.min_key ||
            out_min_value !== e.min_value || out_now_empty !== e.now_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d k=%0d v=%0d e=%0b got st=%0d k=%0d v=%0d e=%0b",
                     e.status, e.min_key, e.min_value, e.now_empty,
                     out_status, out_min_key, out_min_value, out_now_empty);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int ph, n, k;
    for (int i = 0; i < 256; i++) key_slot[i] = ABSENT_SLOT;
    count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed
    push(imh_pkg::ACT_EXTRACT, 8'd0, 0);
    push(imh_pkg::ACT_DECR, 8'd5, 0);
    push(imh_pkg::ACT_INSERT, 8'd0, 32'sh7fffffff);
    push(imh_pkg::ACT_INSERT, 8'd255, 32'sh80000000);
    push(imh_pkg::ACT_INSERT, 8'd255, 0);
    push(imh_pkg::ACT_INSERT, 8'hAA, 7);
    push(imh_pkg::ACT_INSERT, 8'h55, 7);
    push(imh_pkg::ACT_INSERT, 8'h0F, 7);
    push(imh_pkg::ACT_DECR, 8'hAA, 9);
    push(imh_pkg::ACT_DECR, 8'hAA, 7);
    push(imh_pkg::ACT_DECR, 8'h0F, 32'sh80000000);
    push(imh_pkg::ACT_NOP, 8'hFF, -1);
    repeat (6) push(imh_pkg::ACT_EXTRACT, 8'd0, 0);
    push(imh_pkg::ACT_DECR, 8'h0F, 1);

    // fill to capacity, one overflow, random decreases, then drain
    for (int i = 0; i < 256; i++) push(imh_pkg::ACT_INSERT, i[7:0], rand_value());
    push(imh_pkg::ACT_INSERT, 8'd3, 0);
    for (int i = 0; i < 20; i++) push(imh_pkg::ACT_DECR, 8'($urandom()), rand_value());
    for (int i = 0; i < 257; i++) push(imh_pkg::ACT_EXTRACT, 8'($urandom()), rand_value());

    // random phases with small key pool for duplicates and decrease hits
    for (ph = 0; ph < 4; ph++) begin
      wait (pending_reqs.size() == 0);
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 52) : 0;
      recv_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 19 : 0;
      for (n = 0; n < 130; n++) begin
        k = $urandom_range(0, 99) < 70 ? $urandom_range(0, 31) : $urandom_range(0, 255);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push(imh_pkg::ACT_INSERT, k[7:0], rand_value());
          4, 5, 6: push(imh_pkg::ACT_EXTRACT, 8'($urandom()), rand_value());
          7, 8: push(imh_pkg::ACT_DECR, k[7:0], rand_value());
          default: push(imh_pkg::action_t'($urandom_range(0, 3)), 8'($urandom()),
                        rand_value());
        endcase
      end
    end
    wait (pending_reqs.size() == 0);
    @(negedge clk);
    while (in_valid && !in_taken) @(negedge clk);
    wait (expected_resps.size() == 0);
    repeat (60) @(posedge clk);

    $display("checked %0d results over %0d cycles, %0d extractions returned pairs",
             checked, cycles, n_extract);
    $display("covered empty/full/duplicate/absent cases and four idle/stall mixes");
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/imh_pkg.sv
rtl/imh_heap_mem.sv
rtl/imh_map_mem.sv
rtl/indexed_min_heap.sv
rtl/imh_checker.sv
bench/indexed_min_heap_tb.sv
